// File: rtl/bitmap_set_with_minimum_assert.svh
// ---------------------------------------------------------------------------
// bitmap_set_with_minimum_assert.svh
// Assertion macros for the bitmap set. They expand to nothing under SYNTH.
// ---------------------------------------------------------------------------
`ifndef BITMAP_SET_WITH_MINIMUM_ASSERT_SVH
`define BITMAP_SET_WITH_MINIMUM_ASSERT_SVH

`ifndef SYNTH

// The consequent must hold in the same cycle as the antecedent.
`define BSM_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("bitmap set assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define BSM_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("bitmap set assertion failed");

`else

`define BSM_ASSERT_IMP(lbl, ante, cons)
`define BSM_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// File: rtl/bsm_pkg.sv
// ---------------------------------------------------------------------------
// bsm_pkg
// Types, command codes and helper functions of the bitmap set.
// ---------------------------------------------------------------------------
package bsm_pkg;

	localparam int ID_W      = 10;
	localparam int COUNT_W   = 11;
	localparam int WORD_W    = 32;
	localparam int BITSEL_W  = 5;
	localparam int MAX_WORDS = 32;
	localparam int WORDSEL_W = 5;

	typedef logic [1:0]          cmd_t;
	typedef logic [ID_W-1:0]     id_t;
	typedef logic [COUNT_W-1:0]  count_t;
	typedef logic [WORD_W-1:0]   word_t;
	typedef logic [MAX_WORDS-1:0] flags_t;

	localparam cmd_t CMD_ADD   = 2'd0;
	localparam cmd_t CMD_ERASE = 2'd1;
	localparam cmd_t CMD_QUERY = 2'd2;
	localparam cmd_t CMD_CLEAR = 2'd3;

	// Index of the lowest set bit; zero when no bit is set.
	function automatic logic [BITSEL_W-1:0] lowest_set(input word_t w);
		logic [BITSEL_W-1:0] pos;
		pos = '0;
		for (int i = WORD_W - 1; i >= 0; i--) begin
			if (w[i]) begin
				pos = BITSEL_W'(i);
			end
		end
		return pos;
	endfunction

endpackage

// File: rtl/bsm_ram.sv
// ---------------------------------------------------------------------------
// bsm_ram
// Generic synchronous RAM: one write port, two read ports, registered reads
// that update only when the read enable is high.
// ---------------------------------------------------------------------------
module bsm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr_a,
	input  logic [AW-1:0]    raddr_b,
	output logic [WIDTH-1:0] rdata_a,
	output logic [WIDTH-1:0] rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_a <= mem[raddr_a];
			rdata_b <= mem[raddr_b];
		end
	end

endmodule

// File: rtl/bitmap_set_with_minimum.sv
// ---------------------------------------------------------------------------
// bitmap_set_with_minimum
// Set of small integers with add, erase, query and clear, reporting the
// minimum, the member count, emptiness and membership after each command.
// ---------------------------------------------------------------------------
// At acceptance of an item the membership RAM is read at the word of the
// given id and at the lowest other non-empty word; then, in the modify stage,
// once the result register is free, the word is modified, written back and
// the result is formed. No new item is accepted while one is in that stage;
// a stalled result holds one further item there. The set is empty right
// after reset: a register of non-empty flags, one per membership word,
// marks which RAM words hold valid data, so no clearing pass is needed and
// a clear command takes effect at once.
module bitmap_set_with_minimum #(
	parameter int UNIVERSE = 1024
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cmd_valid,
	output logic                  cmd_stall,
	input  bsm_pkg::cmd_t         command,
	input  bsm_pkg::id_t          element_id,
	output logic                  rsp_valid,
	input  logic                  rsp_stall,
	output bsm_pkg::id_t          smallest_element,
	output logic                  set_is_empty,
	output logic                  is_member,
	output bsm_pkg::count_t       member_total
);

	import bsm_pkg::*;

	`include "bitmap_set_with_minimum_assert.svh"

	// Only ids below 1024 can be presented, so at most 32 words are ever used.
	localparam int MAX_MEMBERS = (UNIVERSE < 1024) ? UNIVERSE : 1024;
	localparam int WORDS       = (MAX_MEMBERS + WORD_W - 1) / WORD_W;
	localparam int AW          = (WORDS > 1) ? $clog2(WORDS) : 1;

	flags_t  flags_q;
	count_t  count_q;

	logic                 v_s1;
	cmd_t                 cmd_s1;
	id_t                  id_s1;
	logic                 inr_s1;
	logic                 oth_any_s1;
	logic [WORDSEL_W-1:0] oth_idx_s1;

	logic                 cmd_acc;
	logic                 in_range;
	logic [WORDSEL_W-1:0] wsel;
	flags_t               other;
	logic [WORDSEL_W-1:0] other_idx;

	word_t                rd_a;
	word_t                rd_b;

	logic                 done;
	logic [WORDSEL_W-1:0] w_s1;
	word_t                mask;
	word_t                word_a;
	word_t                new_word;
	logic                 present;
	logic                 do_add;
	logic                 do_erase;
	logic                 is_clear;
	count_t               count_nxt;
	flags_t               flags_nxt;
	logic                 use_a;
	word_t                min_word;
	logic [WORDSEL_W-1:0] min_idx;
	logic                 empty_nxt;

	// ---------------- acceptance and read ----------------
	assign cmd_stall = v_s1;
	assign cmd_acc   = cmd_valid && !v_s1;
	assign in_range  = ({22'd0, element_id} < 32'(UNIVERSE));
	assign wsel      = element_id[ID_W-1:BITSEL_W];

	// The lowest non-empty word other than the one the command touches.
	assign other     = flags_q & ~(in_range ? (flags_t'(1) << wsel) : '0);
	assign other_idx = lowest_set(other);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (cmd_acc) begin
			v_s1 <= 1'b1;
		end else if (done) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_acc) begin
			cmd_s1     <= command;
			id_s1      <= element_id;
			inr_s1     <= in_range;
			oth_any_s1 <= |other;
			oth_idx_s1 <= other_idx;
		end
	end

	bsm_ram #(
		.WIDTH (WORD_W),
		.DEPTH (WORDS),
		.AW    (AW)
	) u_words (
		.clk     (clk),
		.we      (done && (do_add || do_erase)),
		.waddr   (w_s1[AW-1:0]),
		.wdata   (new_word),
		.re      (cmd_acc),
		.raddr_a (wsel[AW-1:0]),
		.raddr_b (other_idx[AW-1:0]),
		.rdata_a (rd_a),
		.rdata_b (rd_b)
	);

	// ---------------- modify, write back, result ----------------
	assign done = v_s1 && (!rsp_valid || !rsp_stall);
	assign w_s1 = id_s1[ID_W-1:BITSEL_W];
	assign mask = word_t'(1) << id_s1[BITSEL_W-1:0];

	// A word whose flag is clear has never been written, was emptied or was cleared.
	assign word_a   = (inr_s1 && flags_q[w_s1]) ? rd_a : '0;
	assign present  = |(word_a & mask);
	assign is_clear = (cmd_s1 == CMD_CLEAR);
	assign do_add   = inr_s1 && (cmd_s1 == CMD_ADD) && !present;
	assign do_erase = inr_s1 && (cmd_s1 == CMD_ERASE) && present;

	always_comb begin
		case (cmd_s1)
			CMD_ADD:   new_word = word_a | mask;
			CMD_ERASE: new_word = word_a & ~mask;
			default:   new_word = word_a;
		endcase
	end

	always_comb begin
		count_nxt = count_q;
		flags_nxt = flags_q;
		if (is_clear) begin
			count_nxt = '0;
			flags_nxt = '0;
		end else if (do_add || do_erase) begin
			count_nxt = do_add ? count_q + 1'b1 : count_q - 1'b1;
			flags_nxt[w_s1] = |new_word;
		end
	end

	// The minimum lies in the touched word if it is non-empty and below the
	// lowest other non-empty word, else in that other word.
	assign use_a     = inr_s1 && (|new_word) && (!oth_any_s1 || (w_s1 < oth_idx_s1));
	assign min_word  = use_a ? new_word : rd_b;
	assign min_idx   = use_a ? w_s1 : oth_idx_s1;
	assign empty_nxt = (count_nxt == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q <= '0;
			count_q <= '0;
		end else if (done) begin
			flags_q <= flags_nxt;
			count_q <= count_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid <= 1'b0;
		end else if (done) begin
			rsp_valid <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			smallest_element <= empty_nxt ? '0 : {min_idx, lowest_set(min_word)};
			set_is_empty     <= empty_nxt;
			is_member        <= !is_clear && inr_s1 && |(new_word & mask);
			member_total     <= count_nxt;
		end
	end

	// ---------------- assertions ----------------
	`BSM_ASSERT_IMP(a_count_bound, 1'b1, count_q <= COUNT_W'(MAX_MEMBERS))
	`BSM_ASSERT_IMP(a_flags_match_count, 1'b1, (count_q == '0) == (flags_q == '0))
	`BSM_ASSERT_IMP(a_empty_result, rsp_valid && set_is_empty, smallest_element == '0 && member_total == '0 && !is_member)
	`BSM_ASSERT_NEXT(a_single_item, v_s1 && !done, v_s1 && $stable(id_s1) && $stable(cmd_s1))

endmodule

// File: tb/bitmap_set_with_minimum_tb.sv
// ---------------------------------------------------------------------------
// bitmap_set_with_minimum_tb
// Self-checking bench for the bitmap set. A queue of commands feeds a
// bursty driver; a monitor with its own stall pattern checks every result
// (minimum, empty flag, membership, count) against a bit-level set kept in
// the bench. The stimulus covers edge cases, windowed random traffic and a
// complete fill of the set.
// ---------------------------------------------------------------------------
module bitmap_set_with_minimum_tb;
	import bsm_pkg::*;

	localparam int SET_SIZE    = 1024;
	localparam int CYCLE_LIMIT = 400000;

	typedef struct {
		cmd_t op;
		id_t  id;
		bit   wait_idle;
	} set_command_t;

	typedef struct {
		id_t    smallest;
		logic   empty;
		logic   member;
		count_t total;
	} set_result_t;

	logic   clk = 1'b0;
	logic   arst_n = 1'b0;
	logic   cmd_valid = 1'b0;
	logic   cmd_stall;
	cmd_t   command = CMD_ADD;
	id_t    element_id = '0;
	logic   rsp_valid;
	logic   rsp_stall = 1'b0;
	id_t    smallest_element;
	logic   set_is_empty;
	logic   is_member;
	count_t member_total;

	set_command_t pending_commands[$];
	set_result_t  expected_results[$];

	logic [SET_SIZE-1:0] set_bits = '0;
	int set_count = 0;

	int error_count = 0;
	int result_index = 0;
	int accepted_total = 0;
	int cycle_count = 0;

	bitmap_set_with_minimum #(
		.UNIVERSE(SET_SIZE)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.command(command),
		.element_id(element_id),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.smallest_element(smallest_element),
		.set_is_empty(set_is_empty),
		.is_member(is_member),
		.member_total(member_total)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// Applies one command to the bench's copy of the set and returns the result
	// the block must produce for it.
	function automatic set_result_t apply_set_command(cmd_t op, id_t id);
		set_result_t r;
		int lowest;
		lowest = 0;
		case (op)
			CMD_CLEAR: begin
				set_bits = '0;
				set_count = 0;
			end
			CMD_ADD: begin
				if (!set_bits[id]) begin
					set_bits[id] = 1'b1;
					set_count++;
				end
			end
			CMD_ERASE: begin
				if (set_bits[id]) begin
					set_bits[id] = 1'b0;
					set_count--;
				end
			end
			default: ;
		endcase
		for (int i = SET_SIZE - 1; i >= 0; i--) begin
			if (set_bits[i]) begin
				lowest = i;
			end
		end
		r.empty    = (set_count == 0);
		r.smallest = r.empty ? id_t'(0) : id_t'(lowest);
		r.member   = (op != CMD_CLEAR) && set_bits[id];
		r.total    = count_t'(set_count);
		return r;
	endfunction

	task automatic report_mismatch(string what);
		$display("tb: mismatch: %s", what);
		error_count++;
	endtask

	task automatic queue_command(cmd_t op, id_t id, bit wait_idle);
		set_command_t c;
		c.op = op;
		c.id = id;
		c.wait_idle = wait_idle;
		pending_commands.push_back(c);
	endtask

	// Driver: bursts of random length separated by random gaps.
	int burst_left = 8;
	int gap_left = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_valid <= 1'b0;
			command <= CMD_ADD;
			element_id <= '0;
		end else begin
			if (cmd_valid && !cmd_stall) begin
				expected_results.push_back(apply_set_command(command, element_id));
				pending_commands.pop_front();
				accepted_total++;
				if (burst_left > 0) begin
					burst_left--;
				end
				if (burst_left == 0) begin
					burst_left = $urandom_range(1, 24);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
				end
			end
			if (!(cmd_valid && cmd_stall)) begin
				if (gap_left > 0) begin
					gap_left--;
					cmd_valid <= 1'b0;
				end else if (pending_commands.size() == 0 ||
						(pending_commands[0].wait_idle && expected_results.size() != 0)) begin
					cmd_valid <= 1'b0;
				end else begin
					cmd_valid <= 1'b1;
					command <= pending_commands[0].op;
					element_id <= pending_commands[0].id;
				end
			end
		end
	end

	// Monitor: checks results and drives the result stall.
	int stall_mode = 0;
	int mode_left = 0;
	int hold_left = 0;
	bit hold_done = 1'b0;

	always @(posedge clk or negedge arst_n) begin
		set_result_t want;
		if (!arst_n) begin
			rsp_stall <= 1'b0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				if (expected_results.size() == 0) begin
					report_mismatch($sformatf("result %0d arrived with none expected",
						result_index));
				end else begin
					want = expected_results.pop_front();
					if (smallest_element !== want.smallest)
						report_mismatch($sformatf("result %0d smallest_element %0d, expected %0d",
							result_index, smallest_element, want.smallest));
					if (set_is_empty !== want.empty)
						report_mismatch($sformatf("result %0d set_is_empty %b, expected %b",
							result_index, set_is_empty, want.empty));
					if (is_member !== want.member)
						report_mismatch($sformatf("result %0d is_member %b, expected %b",
							result_index, is_member, want.member));
					if (member_total !== want.total)
						report_mismatch($sformatf("result %0d member_total %0d, expected %0d",
							result_index, member_total, want.total));
				end
				result_index++;
			end
			// One long hold-off lets the block fill up and stall its input.
			if (hold_left > 0) begin
				hold_left--;
				rsp_stall <= 1'b1;
			end else if (!hold_done && accepted_total >= 200) begin
				hold_done = 1'b1;
				hold_left = 300;
				rsp_stall <= 1'b1;
			end else begin
				if (mode_left == 0) begin
					mode_left = $urandom_range(40, 160);
					stall_mode = $urandom_range(0, 3);
				end else begin
					mode_left--;
				end
				case (stall_mode)
					0: rsp_stall <= 1'b0;
					1: rsp_stall <= ($urandom_range(0, 3) == 0);
					2: rsp_stall <= ($urandom_range(0, 3) != 0);
					default: rsp_stall <= ~rsp_stall;
				endcase
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		int order[SET_SIZE];
		int j;
		int swap;
		int span;
		int base;
		int seg_len;
		int roll;
		cmd_t op;
		id_t id;

		// Edge cases: empty set, top and bottom ids, duplicates, word boundary.
		queue_command(CMD_QUERY, 10'd0, 1'b0);
		queue_command(CMD_ERASE, 10'd7, 1'b0);
		queue_command(CMD_ADD, 10'd1023, 1'b0);
		queue_command(CMD_QUERY, 10'd1023, 1'b0);
		queue_command(CMD_ADD, 10'd1023, 1'b0);
		queue_command(CMD_ADD, 10'd0, 1'b0);
		queue_command(CMD_QUERY, 10'd1023, 1'b0);
		queue_command(CMD_ERASE, 10'd0, 1'b0);
		queue_command(CMD_ERASE, 10'd0, 1'b0);
		queue_command(CMD_ADD, 10'd31, 1'b0);
		queue_command(CMD_ADD, 10'd32, 1'b0);
		queue_command(CMD_ERASE, 10'd31, 1'b0);
		queue_command(CMD_ADD, 10'd682, 1'b0);
		queue_command(CMD_ADD, 10'd341, 1'b0);
		queue_command(CMD_QUERY, 10'd682, 1'b0);
		queue_command(CMD_CLEAR, 10'd341, 1'b0);
		queue_command(CMD_QUERY, 10'd341, 1'b0);
		queue_command(CMD_ADD, 10'd512, 1'b0);
		queue_command(CMD_ERASE, 10'd512, 1'b0);
		queue_command(CMD_CLEAR, 10'd1023, 1'b0);
		queue_command(CMD_ADD, 10'd1023, 1'b1);

		// Random traffic, mostly within narrow id windows so that adds, erases
		// and queries hit the same elements.
		for (int s = 0; s < 8; s++) begin
			span = ($urandom_range(0, 2) == 0) ? SET_SIZE : $urandom_range(4, 40);
			base = $urandom_range(0, SET_SIZE - span);
			seg_len = $urandom_range(10, 20);
			for (int k = 0; k < seg_len; k++) begin
				roll = $urandom_range(0, 99);
				id = id_t'(base + $urandom_range(0, span - 1));
				if (roll < 45)
					op = CMD_ADD;
				else if (roll < 72)
					op = CMD_ERASE;
				else if (roll < 97)
					op = CMD_QUERY;
				else
					op = CMD_CLEAR;
				queue_command(op, id, (k == 0 && s == 4));
			end
		end

		// Fill the whole set in random order, with queries and erase/re-add
		// pairs mixed in, so the count reaches its maximum.
		for (int i = 0; i < SET_SIZE; i++) begin
			order[i] = i;
		end
		for (int i = SET_SIZE - 1; i > 0; i--) begin
			j = $urandom_range(0, i);
			swap = order[i];
			order[i] = order[j];
			order[j] = swap;
		end
		queue_command(CMD_CLEAR, id_t'($urandom_range(0, SET_SIZE - 1)), 1'b1);
		for (int i = 0; i < SET_SIZE; i++) begin
			queue_command(CMD_ADD, id_t'(order[i]), 1'b0);
			if ($urandom_range(0, 9) == 0)
				queue_command(CMD_QUERY, id_t'($urandom_range(0, SET_SIZE - 1)), 1'b0);
			if ($urandom_range(0, 19) == 0) begin
				queue_command(CMD_ERASE, id_t'(order[i]), 1'b0);
				queue_command(CMD_ADD, id_t'(order[i]), 1'b0);
			end
		end
		queue_command(CMD_ADD, id_t'($urandom_range(0, SET_SIZE - 1)), 1'b0);

		// Churn near the bottom of a full set so the minimum moves around.
		for (int k = 0; k < 40; k++) begin
			roll = $urandom_range(0, 99);
			id = ($urandom_range(0, 3) == 0) ? id_t'($urandom_range(0, SET_SIZE - 1))
				: id_t'($urandom_range(0, 63));
			if (roll < 50)
				op = CMD_ERASE;
			else if (roll < 75)
				op = CMD_ADD;
			else
				op = CMD_QUERY;
			queue_command(op, id, 1'b0);
		end
		queue_command(CMD_CLEAR, 10'd0, 1'b0);
		queue_command(CMD_QUERY, 10'd0, 1'b0);

		repeat (6) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		while (pending_commands.size() != 0 || expected_results.size() != 0) begin
			@(posedge clk);
		end
		repeat (20) @(posedge clk);
		if (expected_results.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", expected_results.size()));

		if (error_count == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
